[hw/rtl/tsts_pkg.sv]
// shared types and constants for the tolerant sorted table search
package tsts_pkg;

  localparam int TableDepth = 4096;
  localparam int IdxW = $clog2(TableDepth);
  localparam int LenW = IdxW + 1;
  localparam int ScoreW = 49;
  localparam logic [ScoreW-1:0] ScoreSat = {ScoreW{1'b1}};

  localparam logic [2:0] RegTolerance = 3'd0;
  localparam logic [2:0] RegDiffMode = 3'd1;
  localparam logic [2:0] RegNearest = 3'd2;
  localparam logic [2:0] RegLength = 3'd3;
  localparam logic [2:0] RegNomatch = 3'd4;

  localparam logic [1:0] ModeKey = 2'd1;
  localparam logic [1:0] ModeEntry = 2'd2;

  localparam logic ActWrite = 1'b0;
  localparam logic ActSearch = 1'b1;

  typedef struct packed {
    logic action;
    logic [11:0] entry_index;
    logic signed [31:0] value;
    logic key_missing;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic [15:0] position;
  } out_item_t;

  // divider request / response
  typedef struct packed {
    logic start;
    logic [48:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [48:0] quot;
  } div_rsp_t;

endpackage

[hw/rtl/tolerant_sorted_table_search.sv]
// top level of the tolerant sorted table search
// A write transaction stores one table entry. A search transaction
// binary-searches the first table_length entries with one read of the
// table memory per probe. On a miss with tolerance or nearest mode, it then
// reads the last probe's two neighbours in states S_NBR_L, S_NBR_M and
// S_NBR_R, and the three candidates are scored; relative modes use a
// one-bit-per-cycle divider for each candidate with a nonzero divisor. An
// exact hit goes from its probe straight to the result. One transaction is
// handled at a time. The result goes to an output register, and the next
// input may be taken while it waits; a later result holds in the block until
// that register is free.
module tolerant_sorted_table_search import tsts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_PROBE, S_CMP, S_NBR_L, S_NBR_M, S_NBR_R,
    S_SCORE, S_DIV, S_PICK, S_OUT
  } state_t;

  state_t state;

  logic [31:0] tolerance;
  logic [1:0]  diff_mode;
  logic        nearest_mode;
  logic [12:0] table_length;
  logic [15:0] nomatch_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
      diff_mode <= '0;
      nearest_mode <= 1'b0;
      table_length <= '0;
      nomatch_code <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTolerance: tolerance <= cfg_data;
        RegDiffMode:  diff_mode <= cfg_data[1:0];
        RegNearest:   nearest_mode <= cfg_data[0];
        RegLength:    table_length <= cfg_data[12:0];
        RegNomatch:   nomatch_code <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  in_item_t    item;
  logic [LenW-1:0] len, lo, hi;
  logic [IdxW-1:0] mid, left, right;
  logic signed [1:0] dir;
  logic [31:0] ent_l, ent_m, ent_r;
  logic [1:0]  cand;
  logic [48:0] sl, sm, sr;

  logic            ram_we;
  logic [IdxW-1:0] ram_raddr;
  logic [31:0]     ram_rdata;

  assign ram_we = (state == S_WRITE);

  tsts_table_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(item.entry_index[IdxW-1:0]),
    .wdata(item.value), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  tsts_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [LenW-1:0] mid_c;
  assign mid_c = lo + ((hi - lo) >> 1);

  always_comb begin
    unique case (state)
      S_NBR_L: ram_raddr = left;
      S_NBR_M: ram_raddr = right;
      default: ram_raddr = mid_c[IdxW-1:0];
    endcase
  end

  // score operands for current candidate
  logic signed [31:0] cur_ent;
  logic signed [32:0] d;
  logic [32:0] dmag;
  logic [31:0] den_mag;
  logic [48:0] num;
  logic signed [31:0] key_s;

  assign key_s = item.value;
  always_comb begin
    unique case (cand)
      2'd0: cur_ent = ent_l;
      2'd1: cur_ent = ent_m;
      default: cur_ent = ent_r;
    endcase
  end
  assign d = {key_s[31], key_s} - {cur_ent[31], cur_ent};
  assign dmag = d[32] ? 33'(-d) : 33'(d);
  assign num = {dmag[32:0], 16'd0};
  always_comb begin
    if (diff_mode == ModeKey) den_mag = key_s[31] ? 32'(-key_s) : key_s;
    else den_mag = cur_ent[31] ? 32'(-cur_ent) : cur_ent;
  end

  logic relative;
  assign relative = (diff_mode == ModeKey) || (diff_mode == ModeEntry);

  out_item_t res;
  logic      take_res;
  logic      start_div;

  // result moves to the output register once it is free
  assign take_res = (state == S_OUT) && (!out_valid || !out_stall);
  assign start_div = (state == S_SCORE) && relative && (den_mag != 32'd0);

  function automatic logic acc(input logic [48:0] s, input logic nm,
                               input logic [31:0] tol);
    acc = nm || (s < {17'd0, tol});
  endfunction

  logic al, am, ar;
  assign al = acc(sl, nearest_mode, tolerance);
  assign am = acc(sm, nearest_mode, tolerance);
  assign ar = acc(sr, nearest_mode, tolerance);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= start_div;
      if (take_res) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item <= in_data;
            if (in_data.action == ActWrite) begin
              state <= S_WRITE;
            end else begin
              len <= (table_length > 13'(TableDepth)) ? LenW'(TableDepth)
                                                      : LenW'(table_length);
              lo <= '0;
              hi <= (table_length > 13'(TableDepth)) ? LenW'(TableDepth)
                                                     : LenW'(table_length);
              dir <= 2'sd0;
              if (in_data.key_missing || table_length == 13'd0) begin
                res <= '{found: 1'b0, position: nomatch_code};
                state <= S_OUT;
              end else begin
                state <= S_PROBE;
              end
            end
          end
        end
        S_WRITE: state <= S_IDLE;
        S_PROBE: begin
          mid <= mid_c[IdxW-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (key_s < $signed(ram_rdata)) begin
            dir <= -2'sd1;
            hi <= LenW'(mid);
          end else if (key_s > $signed(ram_rdata)) begin
            dir <= 2'sd1;
            lo <= LenW'(mid) + 1'b1;
          end
          ent_m <= ram_rdata;
          left <= (mid != '0) ? mid - 1'b1 : '0;
          right <= ((LenW'(mid) + 1'b1) < len) ? mid + 1'b1 : IdxW'(len - 1'b1);
          if (key_s == $signed(ram_rdata)) begin
            res <= '{found: 1'b1, position: 16'(mid) + 16'd1};
            state <= S_OUT;
          end else if (((key_s < $signed(ram_rdata)) && LenW'(mid) == lo) ||
                       ((key_s > $signed(ram_rdata)) && LenW'(mid) + 1'b1 == hi)) begin
            if (nearest_mode || tolerance != 32'd0) begin
              state <= S_NBR_L;
            end else begin
              res <= '{found: 1'b0, position: nomatch_code};
              state <= S_OUT;
            end
          end else begin
            state <= S_PROBE;
          end
        end
        S_NBR_L: state <= S_NBR_M;
        S_NBR_M: begin
          ent_l <= ram_rdata;
          state <= S_NBR_R;
        end
        S_NBR_R: begin
          ent_r <= ram_rdata;
          cand <= 2'd0;
          state <= S_SCORE;
        end
        S_SCORE: begin
          if (!relative || den_mag == 32'd0) begin
            logic [48:0] s;
            s = relative ? ScoreSat : num;
            unique case (cand)
              2'd0: sl <= s;
              2'd1: sm <= s;
              default: sr <= s;
            endcase
            if (cand == 2'd2) state <= S_PICK;
            else cand <= cand + 2'd1;
          end else begin
            dreq.num <= num;
            dreq.den <= den_mag;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            unique case (cand)
              2'd0: sl <= drsp.quot;
              2'd1: sm <= drsp.quot;
              default: sr <= drsp.quot;
            endcase
            if (cand == 2'd2) state <= S_PICK;
            else begin
              cand <= cand + 2'd1;
              state <= S_SCORE;
            end
          end
        end
        S_PICK: begin
          priority if (mid == left && dir < 0 && al)
            res <= '{found: 1'b1, position: 16'(left) + 16'd1};
          else if (mid == right && dir > 0 && ar)
            res <= '{found: 1'b1, position: 16'(right) + 16'd1};
          else if (sl <= sm && sl <= sr && al)
            res <= '{found: 1'b1, position: 16'(left) + 16'd1};
          else if (sm <= sl && sm <= sr && am)
            res <= '{found: 1'b1, position: 16'(mid) + 16'd1};
          else if (ar)
            res <= '{found: 1'b1, position: 16'(right) + 16'd1};
          else
            res <= '{found: 1'b0, position: nomatch_code};
          state <= S_OUT;
        end
        S_OUT: begin
          if (take_res) begin
            out_data <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/tsts_table_ram.sv]
// table storage: one write port, one registered read port
module tsts_table_ram import tsts_pkg::*; (
  input  logic            clk,
  input  logic            we,
  input  logic [IdxW-1:0] waddr,
  input  logic [31:0]     wdata,
  input  logic [IdxW-1:0] raddr,
  output logic [31:0]     rdata
);

  logic [31:0] mem [TableDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/tsts_divider.sv]
// restoring divider, one quotient bit per cycle
module tsts_divider import tsts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        quot_ok;
  logic [5:0]  cnt;
  logic [48:0] quot;
  logic [32:0] rem;
  logic [31:0] den;
  logic [32:0] trial;

  assign trial = {rem[31:0], quot[48]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      quot_ok <= 1'b0;
    end else begin
      // done pulses in the cycle after the last quotient bit
      quot_ok <= busy && !req.start && (cnt == 6'd48);
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        quot <= req.num;
        rem <= '0;
        den <= req.den;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quot <= {quot[47:0], 1'b1};
        end else begin
          rem <= trial;
          quot <= {quot[47:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd48) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = '{done: quot_ok, quot: quot};

endmodule

[hw/rtl/tsts_checker.sv]
// port-level checks for the tolerant sorted table search
module tsts_checker import tsts_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_data))
    else $error("unknown bits in a valid result");

  a_take_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("two transactions taken back to back");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tolerant_sorted_table_search tsts_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[bench/tb.sv]
// testbench for the tolerant sorted table search: directed and random transactions
`timescale 1ns / 1ps
module tb;
  import tsts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  tolerant_sorted_table_search i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] entries [TableDepth];
  logic [31:0] tol_q;
  logic [1:0] mode_q;
  logic nearest_q;
  logic [12:0] len_q;
  logic [15:0] nomatch_q;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int accepted_items = 0;
  int queued_items = 0;
  logic quiet_in = 1'b0;
  logic quiet_out = 1'b0;
  logic hold_in = 1'b0;

  function automatic logic [48:0] score(logic signed [31:0] key, logic signed [31:0] ent);
    logic signed [33:0] d;
    logic [32:0] mag_d;
    logic [32:0] den;
    logic [48:0] num;
    d = 34'(key) - 34'(ent);
    mag_d = d < 0 ? 33'(-d) : 33'(d);
    num = 49'(mag_d) << 16;
    if (mode_q == ModeKey) den = key < 0 ? 33'(-34'(key)) : 33'(key);
    else if (mode_q == ModeEntry) den = ent < 0 ? 33'(-34'(ent)) : 33'(ent);
    else return num;
    if (den == 0) return ScoreSat;
    return num / 49'(den);
  endfunction

  function automatic logic ok(logic [48:0] s);
    return nearest_q || s < 49'(tol_q);
  endfunction

  function automatic out_item_t search_result(in_item_t it);
    out_item_t r;
    int unsigned len, lo, hi, mid, lf, rt, pick;
    int dir;
    logic hit, fnd;
    logic [48:0] sl, sm, sr;
    len = len_q > TableDepth ? TableDepth : len_q;
    mid = 0; dir = 0; hit = 0; fnd = 0; pick = 0;
    if (!it.key_missing && len > 0) begin
      lo = 0; hi = len;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (it.value < entries[mid]) begin dir = -1; hi = mid; end
        else if (it.value > entries[mid]) begin dir = 1; lo = mid + 1; end
        else begin hit = 1; break; end
      end
      if (hit) begin
        fnd = 1; pick = mid;
      end else if (nearest_q || tol_q > 0) begin
        lf = mid >= 1 ? mid - 1 : 0;
        rt = mid + 1 < len ? mid + 1 : len - 1;
        sl = score(it.value, entries[lf]);
        sm = score(it.value, entries[mid]);
        sr = score(it.value, entries[rt]);
        if (mid == lf && dir < 0 && ok(sl)) begin fnd = 1; pick = lf; end
        else if (mid == rt && dir > 0 && ok(sr)) begin fnd = 1; pick = rt; end
        else if (sl <= sm && sl <= sr && ok(sl)) begin fnd = 1; pick = lf; end
        else if (sm <= sl && sm <= sr && ok(sm)) begin fnd = 1; pick = mid; end
        else if (ok(sr)) begin fnd = 1; pick = rt; end
      end
    end
    r.found = fnd;
    r.position = fnd ? 16'(pick + 1) : nomatch_q;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accepted_items++;
        if (in_data.action == ActWrite) entries[in_data.entry_index] <= in_data.value;
        else expected_results.push_back(search_result(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && !hold_in &&
            (quiet_in || $urandom_range(99) >= 8)) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result found=%0b position=%0d", $time,
                   out_data.found, out_data.position);
          errors++;
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e.found !== out_data.found)
            $display("%0t: found expected %0b actual %0b", $time, e.found, out_data.found);
          if (e.position !== out_data.position)
            $display("%0t: position expected %0d actual %0d", $time, e.position,
                     out_data.position);
          if (e !== out_data) errors++;
        end
      end
      out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 8);
    end
  end

  task automatic wait_idle();
    while (accepted_items < queued_items || expected_results.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegTolerance: tol_q = val;
      RegDiffMode: mode_q = val[1:0];
      RegNearest: nearest_q = val[0];
      RegLength: len_q = val[12:0];
      RegNomatch: nomatch_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic add_item(logic act, logic [11:0] idx, logic signed [31:0] v, logic miss);
    in_item_t it;
    it.action = act; it.entry_index = idx; it.value = v; it.key_missing = miss;
    pending_items.push_back(it);
    queued_items++;
  endtask

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'sh8000_0000 + $urandom_range(3);
      2: return 32'sh7fff_fffc + $urandom_range(3);
      default: return $signed($urandom_range(4000)) - 2000;
    endcase
  endfunction

  // loads a sorted table of n entries; narrow tables keep keys near zero
  task automatic load_table(int n, logic wide);
    logic signed [31:0] v;
    v = wide ? 32'sh8000_0000 : -32'sd300;
    for (int i = 0; i < n; i++) begin
      add_item(ActWrite, 12'(i), v, 1'($urandom_range(1)));
      if (wide) v = v + $signed(32'($urandom_range(32'h7fff_ffff) / n * 2 / 1));
      else v = v + $signed(32'($urandom_range(40)));
    end
  endtask

  initial begin
    int phase_n;
    tol_q = 0; mode_q = 0; nearest_q = 0; len_q = 0; nomatch_q = 0;
    for (int i = 0; i < TableDepth; i++) entries[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, then a small table with extremes and exact hits
    write_reg(RegNomatch, 32'hbeef);
    add_item(ActSearch, 0, 0, 0);
    load_table(8, 0);
    add_item(ActWrite, 12'hfff, 32'sh7fff_ffff, 0);
    add_item(ActWrite, 12'hffe, 32'sh8000_0000, 0);
    wait_idle();
    write_reg(RegLength, 8);
    add_item(ActSearch, 0, entries[3], 0);
    add_item(ActSearch, 0, entries[0], 1);
    add_item(ActSearch, 0, 32'sh7fff_ffff, 0);
    add_item(ActSearch, 0, 32'sh8000_0000, 0);
    add_item(ActSearch, 0, entries[7] + 1, 0);
    wait_idle();
    write_reg(RegTolerance, 32'hffff_ffff);
    for (int m = 0; m < 4; m++) begin
      write_reg(RegDiffMode, 32'(m));
      add_item(ActSearch, 0, 0, 0);
      add_item(ActSearch, 0, 32'sh8000_0000, 0);
      add_item(ActSearch, 0, entries[2] + 1, 0);
      wait_idle();
    end
    write_reg(RegNearest, 1);
    add_item(ActSearch, 0, 32'sh7fff_ffff, 0);
    add_item(ActSearch, 0, -5, 0);
    wait_idle();

    // random phases over short tables
    for (int p = 0; p < 14; p++) begin
      quiet_in = (p == 5); quiet_out = (p == 5);
      write_reg(RegTolerance, p % 3 == 0 ? 0 : (p % 3 == 1 ? 32'hffff_ffff : $urandom_range(32'h3_0000)));
      write_reg(RegDiffMode, $urandom_range(3));
      write_reg(RegNearest, $urandom_range(1));
      write_reg(RegNomatch, $urandom);
      phase_n = $urandom_range(1, 24);
      load_table(phase_n, 1'($urandom_range(1)));
      wait_idle();
      write_reg(RegLength, $urandom_range(1, 3) == 1 ? $urandom_range(1, phase_n) : phase_n);
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(9) == 0) add_item(ActWrite, 12'($urandom_range(4095)),
                                               entries[12'($urandom_range(4095))], 0);
        else if ($urandom_range(2) == 0)
          add_item(ActSearch, 12'($urandom), entries[$urandom_range(len_q > TableDepth ?
                   TableDepth - 1 : len_q - 1)], $urandom_range(9) == 0);
        else add_item(ActSearch, 12'($urandom), rand_key(), $urandom_range(9) == 0);
        // at least one pause until the block drains
        if (k == 15 && p == 3) begin
          hold_in = 1'b1;
          while (accepted_items < queued_items - int'(pending_items.size()) ||
                 expected_results.size() > 0) @(posedge clk);
          hold_in = 1'b0;
        end
      end
      wait_idle();
    end
    quiet_in = 0; quiet_out = 0;

    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule
